>>> src/c8x_pkg.sv
// shared types and constants for the chip-8 execute unit
`timescale 1ns / 1ps
package c8x_pkg;

   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_ROW   = 2'd3;

   localparam logic [2:0] CSR_RESET_VF = 3'd0;
   localparam logic [2:0] CSR_SHIFT_VX = 3'd1;
   localparam logic [2:0] CSR_JUMP_VX  = 3'd2;
   localparam logic [2:0] CSR_CLIP     = 3'd3;
   localparam logic [2:0] CSR_VBLANK   = 3'd4;
   localparam logic [2:0] CSR_MEM_INC  = 3'd5;

   // call stack and screen geometry; depth and height fixed by the 4-bit sp and 5-bit row index
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;

   // input item fields, packed highest first
   typedef struct packed {
      logic [4:0]  row_index;
      logic [7:0]  mem_data;
      logic [11:0] mem_addr;
      logic [7:0]  random_byte;
      logic [7:0]  delay_value;
      logic        vblank;
      logic [15:0] keys;
      logic [15:0] opcode;
      logic [1:0]  cmd;
   } req_type;

   typedef struct packed {
      logic [63:0] row_data;
      logic [7:0]  read_data;
      logic [7:0]  timer_value;
      logic        sound_write;
      logic        delay_write;
      logic        vblank_clear;
      logic        repeated;
      logic [11:0] next_pc;
   } rsp_type;

   typedef struct packed {
      logic reset_vf;
      logic shift_vx;
      logic jump_vx;
      logic clip;
      logic wait_vblank;
      logic mem_inc;
   } quirk_type;

   // bcd digit split of one byte
   function automatic logic [11:0] bcd8(input logic [7:0] v);
      logic [7:0] h, t, o;
      begin
         h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
         t = v - 8'(h * 8'd100);
         o = t;
         t = 8'((16'(o) * 16'd205) >> 11);
         o = o - 8'(t * 8'd10);
         bcd8 = {h[3:0], t[3:0], o[3:0]};
      end
   endfunction

endpackage

>>> src/c8x_ram.sv
// byte ram, one port, registered read
`timescale 1ns / 1ps
module c8x_ram #(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata_ff
);
   logic [7:0] mem [2**AW];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
endmodule

>>> src/chip8_instruction_execute_unit.sv
// chip-8 execute unit: sequencer over ram, frame buffer, stack and registers
// accept to result: a draw steps through S_DRA, S_DRB and S_DRC once per row,
// register store/load and bcd through S_MEM and S_MEMW once per byte; one item at a time.
// the frame buffer clearing pass after reset accepts no item; 00E0 runs the same
// pass and gives its result when the pass ends.
// reset restores quirks, registers, pc and sp; ram and call stack are undefined.
`timescale 1ns / 1ps
module chip8_instruction_execute_unit #(
   parameter int RAM_BYTES     = 4096,
   parameter int FONT_START    = 80,
   parameter int PROGRAM_START = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd, opcode, keys, vblank, delay_value, random_byte, mem_addr, mem_data,
   // row_index, zero fill
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_pc, repeated, vblank_clear, delay_write, sound_write, timer_value,
   // read_data, row_data, zero fill
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data
);
   localparam int RAW = $clog2(RAM_BYTES);
   localparam int SKW = $clog2(c8x_pkg::STACK_DEPTH);
   localparam int RW  = $clog2(c8x_pkg::SCREEN_HEIGHT);
   localparam int CW  = $clog2(c8x_pkg::SCREEN_WIDTH);

   typedef enum logic [10:0] {
      S_CLR   = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_DEC   = 11'b00000000100,
      S_RAMW  = 11'b00000001000,
      S_DRA   = 11'b00000010000,
      S_DRB   = 11'b00000100000,
      S_DRC   = 11'b00001000000,
      S_MEM   = 11'b00010000000,
      S_MEMW  = 11'b00100000000,
      S_DONE  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff;
   c8x_pkg::quirk_type q_ff;
   c8x_pkg::req_type   r_ff;
   c8x_pkg::rsp_type   o_ff;
   logic [7:0]   v_ff [16];
   logic [11:0]  i_ff, pc_ff;
   logic [3:0]   sp_ff;
   logic [15:0]  lk_ff;
   logic [11:0]  stk [c8x_pkg::STACK_DEPTH];
   logic [11:0]  stk_rd_ff;
   logic [c8x_pkg::SCREEN_WIDTH-1:0] fb [c8x_pkg::SCREEN_HEIGHT];
   logic [c8x_pkg::SCREEN_WIDTH-1:0] fb_rd_ff;
   logic [RW-1:0] fb_addr;
   logic          fb_we;
   logic [c8x_pkg::SCREEN_WIDTH-1:0] fb_wd;
   logic [RW-1:0] clr_ff;
   logic [4:0]   cnt_ff;
   logic [1:0]   sub_ff;
   logic         clear_busy_ff;
   // sprite position held for the whole draw, vf changes while it runs
   logic [CW-1:0] xp_ff;
   logic [RW-1:0] yp_ff;

   logic         ram_we;
   logic [RAW-1:0] ram_addr;
   logic [7:0]   ram_wd, ram_rd;

   c8x_ram #(.AW(RAW)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata_ff(ram_rd)
   );

   wire [15:0] op = r_ff.opcode;
   wire [3:0]  x = op[11:8];
   wire [3:0]  y = op[7:4];
   wire [7:0]  nn = op[7:0];
   wire [7:0]  vx = v_ff[x];
   wire [7:0]  vy = v_ff[y];
   wire [11:0] pc2 = pc_ff + 12'd2;
   wire [CW-1:0] xp = xp_ff;
   wire [RW-1:0] yp = yp_ff;
   wire [7:0] yrow = 8'(yp) + 8'(cnt_ff);
   wire [RW-1:0] prow = RW'(yrow);
   wire [11:0] ia = i_ff + 12'(cnt_ff);
   wire [11:0] bcd = c8x_pkg::bcd8(vx);

   // sprite byte placed at column xp, wrapped or clipped
   logic [c8x_pkg::SCREEN_WIDTH-1:0] smask;
   always_comb begin
      smask = '0;
      for (int c = 0; c < 8; c++) begin
         if (ram_rd[7-c] && !(q_ff.clip && (int'(xp) + c >= c8x_pkg::SCREEN_WIDTH))) begin
            smask[c8x_pkg::SCREEN_WIDTH-1-CW'((int'(xp) + c) % c8x_pkg::SCREEN_WIDTH)] = 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {8'd0, o_ff};

   always_comb begin
      ram_we = 1'b0; ram_addr = RAW'(r_ff.mem_addr); ram_wd = r_ff.mem_data;
      fb_we = 1'b0; fb_addr = r_ff.row_index[RW-1:0]; fb_wd = '0;
      unique case (state_ff)
         S_CLR:  begin fb_we = 1'b1; fb_addr = clr_ff; end
         S_RAMW: begin ram_we = (r_ff.cmd == c8x_pkg::CMD_WRITE); end
         S_DRA:  begin ram_addr = RAW'(ia); fb_addr = prow; end
         S_DRB:  begin ram_addr = RAW'(ia); fb_addr = prow; end
         S_DRC:  begin
            fb_addr = prow;
            fb_we = !(q_ff.clip && yrow >= 8'(c8x_pkg::SCREEN_HEIGHT));
            fb_wd = fb_rd_ff ^ smask;
         end
         S_MEM:  begin ram_addr = RAW'(ia); end
         S_MEMW: begin
            ram_addr = RAW'(ia);
            ram_we = (nn != 8'h65);
            ram_wd = (nn == 8'h33) ? {4'd0, bcd[11-4*cnt_ff[1:0] -: 4]} : v_ff[cnt_ff[3:0]];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb[fb_addr] <= fb_wd;
      end
      fb_rd_ff <= fb[fb_addr];
      stk_rd_ff <= stk[sp_ff[SKW-1:0]];
      if (state_ff == S_DEC && op[15:12] == 4'h2) begin
         stk[SKW'(sp_ff + 4'd1)] <= pc2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0;
         q_ff <= '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
         i_ff <= '0; pc_ff <= 12'(PROGRAM_START); sp_ff <= '0; lk_ff <= '0;
         cnt_ff <= '0; sub_ff <= '0; clear_busy_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               c8x_pkg::CSR_RESET_VF: q_ff.reset_vf    <= csr_data[0];
               c8x_pkg::CSR_SHIFT_VX: q_ff.shift_vx    <= csr_data[0];
               c8x_pkg::CSR_JUMP_VX:  q_ff.jump_vx     <= csr_data[0];
               c8x_pkg::CSR_CLIP:     q_ff.clip        <= csr_data[0];
               c8x_pkg::CSR_VBLANK:   q_ff.wait_vblank <= csr_data[0];
               c8x_pkg::CSR_MEM_INC:  q_ff.mem_inc     <= csr_data[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + RW'(1);
               if (clr_ff == RW'(c8x_pkg::SCREEN_HEIGHT - 1)) begin
                  state_ff <= clear_busy_ff ? S_OUT : S_IDLE;
                  clear_busy_ff <= 1'b0;
               end
            end
            S_IDLE: if (req_tvalid) begin
               r_ff <= c8x_pkg::req_type'(req_tdata[75:0]);
               state_ff <= (req_tdata[1:0] == c8x_pkg::CMD_EXEC) ? S_DEC : S_RAMW;
               cnt_ff <= '0; sub_ff <= '0;
            end
            S_RAMW: begin
               // wait for the registered ram and row read data
               if (sub_ff == 2'd1) begin
                  o_ff <= '0;
                  o_ff.next_pc <= pc_ff;
                  if (r_ff.cmd == c8x_pkg::CMD_READ) o_ff.read_data <= ram_rd;
                  if (r_ff.cmd == c8x_pkg::CMD_ROW &&
                      int'(r_ff.row_index) < c8x_pkg::SCREEN_HEIGHT)
                     o_ff.row_data <= 64'(fb_rd_ff) << (64 - c8x_pkg::SCREEN_WIDTH);
                  state_ff <= S_OUT;
               end
               sub_ff <= sub_ff + 2'd1;
            end
            S_DEC: begin
               o_ff <= '0;
               o_ff.next_pc <= pc2;
               pc_ff <= pc2;
               state_ff <= S_DONE;
               xp_ff <= CW'(vx);
               yp_ff <= RW'(vy);
               case (op[15:12])
                  4'h0: if (op == 16'h00E0) begin
                     clr_ff <= '0; clear_busy_ff <= 1'b1; state_ff <= S_CLR;
                  end else if (op == 16'h00EE) begin
                     pc_ff <= stk_rd_ff; o_ff.next_pc <= stk_rd_ff; sp_ff <= sp_ff - 4'd1;
                  end
                  4'h1: begin pc_ff <= op[11:0]; o_ff.next_pc <= op[11:0]; end
                  4'h2: begin
                     sp_ff <= sp_ff + 4'd1; pc_ff <= op[11:0]; o_ff.next_pc <= op[11:0];
                  end
                  4'h3, 4'h4, 4'h5, 4'h9: begin
                     if ((op[15:12] == 4'h3 && vx == nn) || (op[15:12] == 4'h4 && vx != nn)
                         || (op[15:12] == 4'h5 && op[3:0] == 4'h0 && vx == vy)
                         || (op[15:12] == 4'h9 && op[3:0] == 4'h0 && vx != vy)) begin
                        pc_ff <= pc_ff + 12'd4; o_ff.next_pc <= pc_ff + 12'd4;
                     end
                  end
                  4'h6: v_ff[x] <= nn;
                  4'h7: v_ff[x] <= vx + nn;
                  4'h8: begin
                     case (op[3:0])
                        4'h0: v_ff[x] <= vy;
                        4'h1, 4'h2, 4'h3: begin
                           v_ff[x] <= (op[3:0] == 4'h1) ? (vx | vy) :
                                      (op[3:0] == 4'h2) ? (vx & vy) : (vx ^ vy);
                           if (q_ff.reset_vf) v_ff[15] <= '0;
                        end
                        4'h4: begin
                           v_ff[x] <= vx + vy;
                           v_ff[15] <= 8'({1'b0, vx} + {1'b0, vy} > 9'hFF);
                        end
                        4'h5: begin v_ff[x] <= vx - vy; v_ff[15] <= 8'(vx >= vy); end
                        4'h7: begin v_ff[x] <= vy - vx; v_ff[15] <= 8'(vy >= vx); end
                        4'h6: begin
                           v_ff[x] <= (q_ff.shift_vx ? vx : vy) >> 1;
                           v_ff[15] <= 8'((q_ff.shift_vx ? vx[0] : vy[0]));
                        end
                        4'hE: begin
                           v_ff[x] <= (q_ff.shift_vx ? vx : vy) << 1;
                           v_ff[15] <= 8'((q_ff.shift_vx ? vx[7] : vy[7]));
                        end
                        default: ;
                     endcase
                  end
                  4'hA: i_ff <= op[11:0];
                  4'hB: begin
                     pc_ff <= op[11:0] + 12'(q_ff.jump_vx ? vx : v_ff[0]);
                     o_ff.next_pc <= op[11:0] + 12'(q_ff.jump_vx ? vx : v_ff[0]);
                  end
                  4'hC: v_ff[x] <= r_ff.random_byte & nn;
                  4'hD: if (!r_ff.vblank) begin
                     pc_ff <= pc_ff; o_ff.next_pc <= pc_ff; o_ff.repeated <= 1'b1;
                  end else begin
                     o_ff.vblank_clear <= q_ff.wait_vblank;
                     v_ff[15] <= '0;
                     if (op[3:0] != 4'd0) state_ff <= S_DRA;
                  end
                  4'hE: if ((nn == 8'h9E && r_ff.keys[vx[3:0]])
                            || (nn == 8'hA1 && !r_ff.keys[vx[3:0]])) begin
                     pc_ff <= pc_ff + 12'd4; o_ff.next_pc <= pc_ff + 12'd4;
                  end
                  4'hF: case (nn)
                     8'h07: v_ff[x] <= r_ff.delay_value;
                     8'h0A: if (lk_ff == '0 || r_ff.keys != '0) begin
                        lk_ff <= r_ff.keys;
                        pc_ff <= pc_ff; o_ff.next_pc <= pc_ff; o_ff.repeated <= 1'b1;
                     end else begin
                        for (int k = 0; k < 16; k++) if (lk_ff[k]) v_ff[x] <= 8'(k);
                        lk_ff <= '0;
                     end
                     8'h15: begin o_ff.delay_write <= 1'b1; o_ff.timer_value <= vx; end
                     8'h18: begin o_ff.sound_write <= 1'b1; o_ff.timer_value <= vx; end
                     8'h1E: i_ff <= i_ff + 12'(vx);
                     8'h29: i_ff <= 12'(FONT_START) + 12'(vx[3:0]) * 12'd5;
                     8'h33, 8'h55, 8'h65: state_ff <= S_MEM;
                     default: ;
                  endcase
                  default: ;
               endcase
            end
            S_DRA: state_ff <= S_DRB;
            S_DRB: begin
               if (|(fb_rd_ff & smask) && !(q_ff.clip && yrow >= 8'(c8x_pkg::SCREEN_HEIGHT)))
                  v_ff[15] <= 8'd1;
               state_ff <= S_DRC;
            end
            S_DRC: begin
               cnt_ff <= cnt_ff + 5'd1;
               state_ff <= (cnt_ff + 5'd1 == 5'(op[3:0])) ? S_DONE : S_DRA;
            end
            S_MEM: state_ff <= S_MEMW;
            S_MEMW: begin
               if (nn == 8'h65) v_ff[cnt_ff[3:0]] <= ram_rd;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == ((nn == 8'h33) ? 5'd2 : 5'(x))) begin
                  state_ff <= S_DONE;
                  if (nn != 8'h33 && q_ff.mem_inc) i_ff <= i_ff + 12'(x) + 12'd1;
               end else begin
                  state_ff <= S_MEM;
               end
            end
            S_DONE: state_ff <= S_OUT;
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> src/c8x_checker.sv
// port-level checks for the chip-8 execute unit
`timescale 1ns / 1ps
module c8x_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("accepted while result pending");
   a_after: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result in the cycle after accept");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind chip8_instruction_execute_unit c8x_checker u_c8x_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

>>> verif/tb_top.sv
// self-checking testbench for the chip-8 execute unit
`timescale 1ns / 1ps
module tb_top;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 500;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   chip8_instruction_execute_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // execution model state
   c8x_pkg::quirk_type quirks;
   logic [7:0]  vreg [16];
   logic [11:0] index_reg;
   logic [11:0] pc;
   logic [3:0]  sp;
   logic [11:0] stack_mem [16];
   bit          stack_valid [16];
   logic [7:0]  ram [4096];
   bit          ram_valid [4096];
   logic [63:0] screen [32];
   logic [15:0] held_keys;

   c8x_pkg::req_type pending_req_q [$];
   c8x_pkg::rsp_type expected_rsp_q [$];

   int  sender_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_fire;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_count = 0;

   // true when n bytes from base have all been written
   function automatic bit ram_span_ok(input logic [11:0] base, input int n);
      for (int i = 0; i < n; i++)
         if (!ram_valid[12'(base + 12'(i))]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic draw_sprite(input logic [15:0] op);
      int xp, yp, h, py, px;
      logic [7:0] bits;
      xp = vreg[op[11:8]] % 64;
      yp = vreg[op[7:4]] % 32;
      h = op[3:0];
      vreg[15] = 8'd0;
      for (int r = 0; r < h; r++) begin
         bits = ram[12'(index_reg + 12'(r))];
         for (int c = 0; c < 8; c++) begin
            if (quirks.clip && (yp + r >= 32 || xp + c >= 64))
               break;
            py = (yp + r) % 32;
            px = (xp + c) % 64;
            if (bits[7 - c] && screen[py][63 - px])
               vreg[15] = 8'd1;
            screen[py][63 - px] ^= bits[7 - c];
         end
      end
   endtask

   task automatic execute_item(input c8x_pkg::req_type r, output c8x_pkg::rsp_type o);
      logic [3:0]  x, y;
      logic [7:0]  nn, vx, vy, s;
      logic [11:0] nnn;
      logic        f;
      o = '0;
      x = r.opcode[11:8];
      y = r.opcode[7:4];
      nn = r.opcode[7:0];
      nnn = r.opcode[11:0];
      case (r.cmd)
         c8x_pkg::CMD_WRITE: begin
            ram[r.mem_addr] = r.mem_data;
            ram_valid[r.mem_addr] = 1'b1;
         end
         c8x_pkg::CMD_READ:  o.read_data = ram[r.mem_addr];
         c8x_pkg::CMD_ROW:   o.row_data = screen[r.row_index];
         default: begin
            pc = pc + 12'd2;
            vx = vreg[x];
            vy = vreg[y];
            case (r.opcode[15:12])
               4'h0: begin
                  if (r.opcode == 16'h00E0) begin
                     for (int i = 0; i < 32; i++) screen[i] = '0;
                  end else if (r.opcode == 16'h00EE) begin
                     pc = stack_mem[sp];
                     sp = sp - 4'd1;
                  end
               end
               4'h1: pc = nnn;
               4'h2: begin
                  sp = sp + 4'd1;
                  stack_mem[sp] = pc;
                  stack_valid[sp] = 1'b1;
                  pc = nnn;
               end
               4'h3: if (vx == nn) pc = pc + 12'd2;
               4'h4: if (vx != nn) pc = pc + 12'd2;
               4'h5: if (r.opcode[3:0] == 4'h0 && vx == vy) pc = pc + 12'd2;
               4'h6: vreg[x] = nn;
               4'h7: vreg[x] = vx + nn;
               4'h8: begin
                  case (r.opcode[3:0])
                     4'h0: vreg[x] = vy;
                     4'h1: begin vreg[x] = vx | vy; if (quirks.reset_vf) vreg[15] = 8'd0; end
                     4'h2: begin vreg[x] = vx & vy; if (quirks.reset_vf) vreg[15] = 8'd0; end
                     4'h3: begin vreg[x] = vx ^ vy; if (quirks.reset_vf) vreg[15] = 8'd0; end
                     4'h4: begin
                        f = (9'(vx) + 9'(vy)) > 9'hFF;
                        vreg[x] = vx + vy; vreg[15] = 8'(f);
                     end
                     4'h5: begin
                        f = vx >= vy;
                        vreg[x] = vx - vy; vreg[15] = 8'(f);
                     end
                     4'h6: begin
                        s = quirks.shift_vx ? vx : vy;
                        vreg[x] = s >> 1; vreg[15] = 8'(s[0]);
                     end
                     4'h7: begin
                        f = vy >= vx;
                        vreg[x] = vy - vx; vreg[15] = 8'(f);
                     end
                     4'hE: begin
                        s = quirks.shift_vx ? vx : vy;
                        vreg[x] = s << 1; vreg[15] = 8'(s[7]);
                     end
                     default: ;
                  endcase
               end
               4'h9: if (r.opcode[3:0] == 4'h0 && vx != vy) pc = pc + 12'd2;
               4'hA: index_reg = nnn;
               4'hB: pc = nnn + 12'(vreg[quirks.jump_vx ? x : 4'd0]);
               4'hC: vreg[x] = r.random_byte & nn;
               4'hD: begin
                  if (!r.vblank) begin
                     pc = pc - 12'd2;
                     o.repeated = 1'b1;
                  end else begin
                     o.vblank_clear = quirks.wait_vblank;
                     draw_sprite(r.opcode);
                  end
               end
               4'hE: begin
                  if (nn == 8'h9E && r.keys[vx[3:0]]) pc = pc + 12'd2;
                  else if (nn == 8'hA1 && !r.keys[vx[3:0]]) pc = pc + 12'd2;
               end
               4'hF: begin
                  case (nn)
                     8'h07: vreg[x] = r.delay_value;
                     8'h0A: begin
                        if (held_keys == 16'd0 || r.keys != 16'd0) begin
                           held_keys = r.keys;
                           pc = pc - 12'd2;
                           o.repeated = 1'b1;
                        end else begin
                           for (int i = 0; i < 16; i++)
                              if (held_keys[i]) vreg[x] = 8'(i);
                           held_keys = 16'd0;
                        end
                     end
                     8'h15: begin o.delay_write = 1'b1; o.timer_value = vx; end
                     8'h18: begin o.sound_write = 1'b1; o.timer_value = vx; end
                     8'h1E: index_reg = index_reg + 12'(vx);
                     8'h29: index_reg = 12'd80 + 12'd5 * 12'(vx[3:0]);
                     8'h33: begin
                        ram[index_reg] = vx / 8'd100;
                        ram[12'(index_reg + 12'd1)] = (vx / 8'd10) % 8'd10;
                        ram[12'(index_reg + 12'd2)] = vx % 8'd10;
                        for (int i = 0; i < 3; i++) ram_valid[12'(index_reg + 12'(i))] = 1'b1;
                     end
                     8'h55: begin
                        for (int i = 0; i <= x; i++) begin
                           ram[12'(index_reg + 12'(i))] = vreg[i];
                           ram_valid[12'(index_reg + 12'(i))] = 1'b1;
                        end
                        if (quirks.mem_inc) index_reg = index_reg + 12'(x) + 12'd1;
                     end
                     8'h65: begin
                        for (int i = 0; i <= x; i++) vreg[i] = ram[12'(index_reg + 12'(i))];
                        if (quirks.mem_inc) index_reg = index_reg + 12'(x) + 12'd1;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      endcase
      o.next_pc = pc;
   endtask

   function automatic c8x_pkg::req_type random_req(input logic [1:0] cmd,
                                                   input logic [15:0] op);
      c8x_pkg::req_type r;
      r.cmd = cmd;
      r.opcode = op;
      r.keys = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
      r.vblank = ($urandom_range(0, 4) != 0);
      r.delay_value = 8'($urandom);
      r.random_byte = 8'($urandom);
      r.mem_addr = 12'($urandom);
      r.mem_data = 8'($urandom);
      r.row_index = 5'($urandom);
      return r;
   endfunction

   task automatic issue(input c8x_pkg::req_type r);
      c8x_pkg::rsp_type e;
      execute_item(r, e);
      pending_req_q.push_back(r);
      expected_rsp_q.push_back(e);
   endtask

   task automatic exec_op(input logic [15:0] op);
      issue(random_req(c8x_pkg::CMD_EXEC, op));
   endtask

   // draw and register load picks only read bytes written earlier; the fully random pick is unchecked
   function automatic logic [15:0] random_opcode();
      logic [3:0]  x, y;
      logic [7:0]  nn;
      logic [15:0] op;
      int          h;
      x = 4'($urandom);
      y = 4'($urandom);
      nn = 8'($urandom);
      op = 16'($urandom);
      case ($urandom_range(0, 21))
         0:  return ($urandom_range(0, 5) == 0) ? 16'h00E0 : {4'h6, x, nn};
         1:  return stack_valid[sp] ? 16'h00EE : {4'h7, x, nn};
         2:  return {4'h1, op[11:0]};
         3:  return {4'h2, op[11:0]};
         4:  return {4'h3, x, $urandom_range(0, 1) ? vreg[x] : nn};
         5:  return {4'h4, x, $urandom_range(0, 1) ? vreg[x] : nn};
         6:  return {4'h5, x, y, ($urandom_range(0, 4) == 0) ? op[3:0] : 4'h0};
         7:  return {4'h6, x, nn};
         8:  return {4'h7, x, nn};
         9, 10, 11: begin
            case ($urandom_range(0, 9))
               0: return {4'h8, x, y, op[3:0]};
               1: return {4'h8, x, y, 4'hE};
               default: return {4'h8, x, y, 4'($urandom_range(0, 7))};
            endcase
         end
         12: return {4'h9, x, y, ($urandom_range(0, 4) == 0) ? op[3:0] : 4'h0};
         13: return {4'hA, $urandom_range(0, 1) ? op[11:0] : 12'($urandom_range(0, 63))};
         14: return {4'hB, op[11:0]};
         15: return {4'hC, x, nn};
         16, 17: begin
            h = int'(op[3:0]);
            while (h > 0 && !ram_span_ok(index_reg, h)) h--;
            return {4'hD, x, y, 4'(h)};
         end
         18: return {4'hE, x, $urandom_range(0, 1) ? 8'h9E : 8'hA1};
         19, 20: begin
            case ($urandom_range(0, 9))
               0: return {4'hF, x, 8'h07};
               1: return {4'hF, x, 8'h0A};
               2: return {4'hF, x, 8'h15};
               3: return {4'hF, x, 8'h18};
               4: return {4'hF, x, 8'h1E};
               5: return {4'hF, x, 8'h29};
               6: return {4'hF, x, 8'h33};
               7: return {4'hF, x, 8'h55};
               8: return ram_span_ok(index_reg, int'(x) + 1) ? {4'hF, x, 8'h65}
                                                              : {4'hF, x, 8'h55};
               default: return {4'hF, x, nn};
            endcase
         end
         default: return op;
      endcase
   endfunction

   task automatic random_items(input int count);
      int pick;
      c8x_pkg::req_type r;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) exec_op(random_opcode());
         else if (pick == 7) issue(random_req(c8x_pkg::CMD_WRITE, 16'($urandom)));
         else if (pick == 8) begin
            r = random_req(c8x_pkg::CMD_READ, 16'($urandom));
            if ($urandom_range(0, 1) == 0) r.mem_addr = 12'($urandom_range(0, 63));
            if (!ram_valid[r.mem_addr]) r.cmd = c8x_pkg::CMD_WRITE;
            issue(r);
         end
         else issue(random_req(c8x_pkg::CMD_ROW, 16'($urandom)));
      end
   endtask

   task automatic wait_idle();
      wait (pending_req_q.size() == 0 && expected_rsp_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= {7'd0, val};
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         c8x_pkg::CSR_RESET_VF: quirks.reset_vf = val;
         c8x_pkg::CSR_SHIFT_VX: quirks.shift_vx = val;
         c8x_pkg::CSR_JUMP_VX:  quirks.jump_vx = val;
         c8x_pkg::CSR_CLIP:     quirks.clip = val;
         c8x_pkg::CSR_VBLANK:   quirks.wait_vblank = val;
         default:               quirks.mem_inc = val;
      endcase
   endtask

   task automatic set_quirks(input logic [5:0] q);
      csr_write(c8x_pkg::CSR_RESET_VF, q[5]);
      csr_write(c8x_pkg::CSR_SHIFT_VX, q[4]);
      csr_write(c8x_pkg::CSR_JUMP_VX, q[3]);
      csr_write(c8x_pkg::CSR_CLIP, q[2]);
      csr_write(c8x_pkg::CSR_VBLANK, q[1]);
      csr_write(c8x_pkg::CSR_MEM_INC, q[0]);
   endtask

   // sender
   always @(posedge clock) req_fire = req_tvalid && req_tready;

   always @(negedge clock) begin
      logic   next_valid;
      c8x_pkg::req_type r;
      next_valid = req_tvalid && !req_fire;
      if (!next_valid && pending_req_q.size() != 0 && !reset &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
         r = pending_req_q.pop_front();
         req_tdata <= {4'd0, r};
         next_valid = 1'b1;
      end
      req_tvalid <= next_valid;
   end

   // receiver
   always @(negedge clock)
      rsp_tready <= !(hold_go && !hold_done) && ($urandom_range(0, 99) >= recv_stall_pct);

   // long receiver hold-off so the unit backs up into its input
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
         else hold_count <= hold_count + 1;
      end
   end

   always @(posedge clock) begin
      c8x_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[95:0];
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %h", got);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.next_pc !== want.next_pc || got.repeated !== want.repeated ||
                got.vblank_clear !== want.vblank_clear ||
                got.delay_write !== want.delay_write ||
                got.sound_write !== want.sound_write ||
                got.timer_value !== want.timer_value ||
                got.read_data !== want.read_data || got.row_data !== want.row_data) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: pc %h/%h rep %b/%b vbc %b/%b dw %b/%b ",
                     want.next_pc, got.next_pc, want.repeated, got.repeated,
                     want.vblank_clear, got.vblank_clear, want.delay_write, got.delay_write);
                  $display("sw %b/%b tv %h/%h rd %h/%h row %h/%h",
                     want.sound_write, got.sound_write, want.timer_value, got.timer_value,
                     want.read_data, got.read_data, want.row_data, got.row_data);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("chip8_instruction_execute_unit test failed");
         $finish;
      end
   end

   initial begin
      quirks = '{reset_vf: 1'b1, shift_vx: 1'b0, jump_vx: 1'b0, clip: 1'b1,
                 wait_vblank: 1'b1, mem_inc: 1'b1};
      for (int i = 0; i < 16; i++) begin
         vreg[i] = '0;
         stack_mem[i] = '0;
         stack_valid[i] = 1'b0;
      end
      for (int i = 0; i < 32; i++) screen[i] = '0;
      index_reg = '0;
      pc = 12'd512;
      sp = '0;
      held_keys = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ram is undefined after reset: load a low block, later reads follow writes
      for (int a = 0; a < 64; a++) begin
         c8x_pkg::req_type r;
         r = random_req(c8x_pkg::CMD_WRITE, 16'($urandom));
         r.mem_addr = 12'(a);
         issue(r);
      end
      wait_idle();

      // directed: extremes, flag cases, waits, stack, clip
      exec_op(16'h6FFF);
      exec_op(16'h60FF);
      exec_op(16'h8F04);                 // flag overwrites the sum in vf
      exec_op(16'h8015);
      exec_op(16'h8106);
      exec_op(16'h810E);
      exec_op(16'h8017);
      exec_op(16'h8F01);
      exec_op(16'h8123);                 // 8xy3 with vf clear
      exec_op(16'h5121);                 // nonzero low nibble: pc only
      exec_op(16'h9121);
      exec_op(16'hAFFF);
      exec_op(16'hF01E);                 // index wraps past 0xfff
      exec_op(16'hFF33);
      exec_op(16'hFF55);
      exec_op(16'hA0FE);                 // back to the bytes just stored
      exec_op(16'hFF65);
      exec_op(16'hA0FE);
      exec_op(16'h603F);
      exec_op(16'h611F);
      begin
         c8x_pkg::req_type r;
         r = random_req(c8x_pkg::CMD_EXEC, 16'hD01F);
         r.vblank = 1'b0;                // draw waits for a frame boundary
         issue(r);
         r.vblank = 1'b1;                // corner sprite, clipped or wrapped
         issue(r);
         r = random_req(c8x_pkg::CMD_EXEC, 16'hF30A);
         r.keys = 16'hFFFF;
         issue(r);
         r.keys = 16'h0000;              // key released: wait completes
         issue(r);
      end
      exec_op(16'h2FFE);
      exec_op(16'h00EE);
      exec_op(16'hBFFF);
      issue(random_req(c8x_pkg::CMD_ROW, 16'h0000));
      wait_idle();

      // all quirks off
      set_quirks(6'b000000);
      random_items(75);
      wait_idle();

      // all quirks on, sender mostly idle
      set_quirks(6'b111111);
      sender_idle_pct = 83;
      random_items(75);
      wait_idle();

      // random quirks, receiver mostly stalled
      set_quirks(6'($urandom));
      sender_idle_pct = 0;
      recv_stall_pct = 83;
      random_items(75);
      wait_idle();

      // defaults, both sides idle, and one long hold-off
      set_quirks(6'b100111);
      sender_idle_pct = 20;
      recv_stall_pct = 20;
      @(negedge clock);
      hold_go <= 1'b1;
      random_items(75);
      wait_idle();

      if (mismatches == 0)
         $display("chip8_instruction_execute_unit test passed");
      else
         $display("chip8_instruction_execute_unit test failed");
      $finish;
   end

endmodule
